[rtl/nrc_pkg.sv]
// nrc_pkg: shared types and constants for the nearest reference color block.
// Transaction structs, command codes and the sequencer state type.
// No dependencies.
package nrc_pkg;

  localparam int unsigned TableEntriesDef = 32;
  localparam int unsigned IndexW          = 5;
  localparam int unsigned ChanW           = 8;
  localparam int unsigned CountW          = 6;
  localparam int unsigned DistW           = 18;

  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } nrc_state_e;

  typedef struct packed {
    logic              command;
    logic [IndexW-1:0] entry_index;
    logic [ChanW-1:0]  sensed_r;
    logic [ChanW-1:0]  sensed_g;
    logic [ChanW-1:0]  sensed_b;
    logic [ChanW-1:0]  ideal_r;
    logic [ChanW-1:0]  ideal_g;
    logic [ChanW-1:0]  ideal_b;
  } nrc_item_t;

  typedef struct packed {
    logic              found;
    logic [IndexW-1:0] match_index;
    logic [DistW-1:0]  best_distance_sq;
    logic [ChanW-1:0]  out_r;
    logic [ChanW-1:0]  out_g;
    logic [ChanW-1:0]  out_b;
  } nrc_result_t;

  typedef struct packed {
    logic [ChanW-1:0] sr;
    logic [ChanW-1:0] sg;
    logic [ChanW-1:0] sb;
    logic [ChanW-1:0] ir;
    logic [ChanW-1:0] ig;
    logic [ChanW-1:0] ib;
  } nrc_entry_t;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } nrc_rgb_t;

endpackage

[rtl/nearest_reference_color.sv]
// nearest_reference_color: reference color table with nearest-match search.
// Depends on nrc_pkg (types, command codes, state enum).
//
// Usage
//   Input channel: item_i is taken at a rising edge where start is high and
//   busy is low. A load transaction (command = load) writes one table entry
//   in that cycle; busy stays low, so loads can go back to back. A load whose
//   entry_index is at or beyond TABLE_ENTRIES is dropped.
//   A classify transaction raises busy and walks entries 0 .. n-1, where n is
//   entry_count saturated at TABLE_ENTRIES. One entry is read from the table
//   RAM per cycle; a three-stage loop (RAM read, distance, compare) shares one
//   distance unit and one comparator across all entries.
//   Result channel: result_valid_o is high for exactly one cycle with
//   result_o; the receiver cannot stall, so it must take it then.
//   Result strobe follows the scan; busy drops the cycle after the strobe.
//   The single RAM read port feeds one entry per cycle, so the length of a
//   classify grows with n. Ties resolve to the lowest index (strict
//   less-than compare).
//   Config: cfg_we_i writes entry_count (6 bits); only change it while idle.
//   Reset: asynchronous, active low. Clears entry_count and the sequencer;
//   table contents are undefined until loaded, and searching an unloaded
//   entry gives undefined fields.
module nearest_reference_color #(
  parameter int unsigned TABLE_ENTRIES = nrc_pkg::TableEntriesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  nrc_pkg::nrc_item_t          item_i,
  output logic                        result_valid_o,
  output nrc_pkg::nrc_result_t        result_o,
  input  logic                        cfg_we_i,
  input  logic [nrc_pkg::CountW-1:0]  cfg_wdata_i
);

  // Address and counter widths follow the table depth.
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  // Compare widths wide enough for both operands.
  localparam int unsigned SW = (CW > nrc_pkg::CountW) ? CW : nrc_pkg::CountW;
  localparam int unsigned LW = (CW > nrc_pkg::IndexW) ? CW : nrc_pkg::IndexW;

  // Sequencer state
  nrc_pkg::nrc_state_e state_q, state_d;

  // Config register
  logic [nrc_pkg::CountW-1:0] entry_count_q;

  // Control
  logic          accept;
  logic          classify_go;
  logic          mem_we;
  logic          issue_en;
  logic          upd;
  logic [CW-1:0] issue_cnt_q;
  logic [CW-1:0] n_q, n_d;
  logic          v1_q;   // RAM read data valid
  logic          v2_q;   // distance valid
  logic          have_q; // at least one entry compared

  // Table RAM: one write port (loads), one registered read port (scan)
  nrc_pkg::nrc_entry_t ref_mem_q [TABLE_ENTRIES];
  nrc_pkg::nrc_entry_t rdata_q;
  logic [AW-1:0]       idx1_q;

  // Payload registers
  nrc_pkg::nrc_rgb_t         sample_q;
  logic [nrc_pkg::DistW-1:0] dist_d, dist_q;
  logic [AW-1:0]             idx2_q;
  nrc_pkg::nrc_rgb_t         ideal2_q;
  logic [nrc_pkg::DistW-1:0] best_d_q;
  logic [AW-1:0]             best_idx_q;
  nrc_pkg::nrc_rgb_t         best_rgb_q;

  // Saturation and range checks
  logic [SW-1:0] count_ext;
  logic          load_in_range;

  assign count_ext     = SW'(entry_count_q);
  assign n_d           = (count_ext > SW'(TABLE_ENTRIES)) ? CW'(TABLE_ENTRIES)
                                                          : CW'(count_ext);
  assign load_in_range = LW'(item_i.entry_index) < LW'(TABLE_ENTRIES);

  // Shared distance unit: three 8x8 squares and a sum, one entry per cycle
  logic [nrc_pkg::ChanW-1:0] dr, dg, db;
  logic [2*nrc_pkg::ChanW-1:0] sqr, sqg, sqb;

  assign dr  = (sample_q.r > rdata_q.sr) ? (sample_q.r - rdata_q.sr)
                                         : (rdata_q.sr - sample_q.r);
  assign dg  = (sample_q.g > rdata_q.sg) ? (sample_q.g - rdata_q.sg)
                                         : (rdata_q.sg - sample_q.g);
  assign db  = (sample_q.b > rdata_q.sb) ? (sample_q.b - rdata_q.sb)
                                         : (rdata_q.sb - sample_q.b);
  assign sqr = dr * dr;
  assign sqg = dg * dg;
  assign sqb = db * db;
  assign dist_d = nrc_pkg::DistW'(sqr) + nrc_pkg::DistW'(sqg) + nrc_pkg::DistW'(sqb);

  // Compare stage: first entry always takes, later only on strictly smaller
  assign upd = v2_q && (!have_q || (dist_q < best_d_q));

  // Sequencer: next state and strobes
  always_comb begin
    state_d        = state_q;
    busy           = (state_q != nrc_pkg::ST_IDLE);
    result_valid_o = (state_q == nrc_pkg::ST_RESULT);
    accept         = start && !busy;
    classify_go    = 1'b0;
    mem_we         = 1'b0;
    issue_en       = 1'b0;
    case (state_q)
      nrc_pkg::ST_IDLE: begin
        if (accept) begin
          if (item_i.command == nrc_pkg::CMD_CLASSIFY) begin
            classify_go = 1'b1;
            state_d     = nrc_pkg::ST_SCAN;
          end else begin
            mem_we = load_in_range;
          end
        end
      end
      nrc_pkg::ST_SCAN: begin
        if (issue_cnt_q < n_q) begin
          issue_en = 1'b1;
        end else if (!v1_q && !v2_q) begin
          state_d = nrc_pkg::ST_RESULT;
        end
      end
      nrc_pkg::ST_RESULT: begin
        state_d = nrc_pkg::ST_IDLE;
      end
      default: begin
        state_d = nrc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nrc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      issue_cnt_q   <= '0;
      n_q           <= '0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      have_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        entry_count_q <= cfg_wdata_i;
      end
      if (classify_go) begin
        issue_cnt_q <= '0;
        n_q         <= n_d;
      end else if (issue_en) begin
        issue_cnt_q <= issue_cnt_q + 1'b1;
      end
      v1_q <= issue_en;
      v2_q <= v1_q;
      if (classify_go) begin
        have_q <= 1'b0;
      end else if (upd) begin
        have_q <= 1'b1;
      end
    end
  end

  // Table RAM
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ref_mem_q[AW'(item_i.entry_index)] <= '{sr: item_i.sensed_r, sg: item_i.sensed_g,
                                             sb: item_i.sensed_b, ir: item_i.ideal_r,
                                             ig: item_i.ideal_g,  ib: item_i.ideal_b};
    end
    if (issue_en) begin
      rdata_q <= ref_mem_q[issue_cnt_q[AW-1:0]];
      idx1_q  <= issue_cnt_q[AW-1:0];
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (classify_go) begin
      sample_q <= '{r: item_i.sensed_r, g: item_i.sensed_g, b: item_i.sensed_b};
    end
    if (v1_q) begin
      dist_q   <= dist_d;
      idx2_q   <= idx1_q;
      ideal2_q <= '{r: rdata_q.ir, g: rdata_q.ig, b: rdata_q.ib};
    end
    if (upd) begin
      best_d_q   <= dist_q;
      best_idx_q <= idx2_q;
      best_rgb_q <= ideal2_q;
    end
  end

  // Result: empty table passes the sample through
  always_comb begin
    result_o.found = have_q;
    if (have_q) begin
      result_o.match_index      = nrc_pkg::IndexW'(best_idx_q);
      result_o.best_distance_sq = best_d_q;
      result_o.out_r            = best_rgb_q.r;
      result_o.out_g            = best_rgb_q.g;
      result_o.out_b            = best_rgb_q.b;
    end else begin
      result_o.match_index      = '0;
      result_o.best_distance_sq = '0;
      result_o.out_r            = sample_q.r;
      result_o.out_g            = sample_q.g;
      result_o.out_b            = sample_q.b;
    end
  end

`ifndef ASSERT_OFF
  // Result strobe lasts one cycle and then the block frees up
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o && !busy)
    else $error("result strobe longer than one cycle");

  // A classify transaction always makes the block busy
  a_classify_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.command == nrc_pkg::CMD_CLASSIFY) |=> busy)
    else $error("classify accepted without going busy");

  // A load never starts a search
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.command == nrc_pkg::CMD_LOAD) |=> !busy)
    else $error("load transaction made the block busy");

  // Scan never issues past the saturated entry count
  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nrc_pkg::ST_SCAN) |-> (issue_cnt_q <= n_q))
    else $error("scan counter ran past entry count");

  // Found only if the table was not empty
  a_found_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.found) |-> (n_q != '0))
    else $error("match reported for an empty table");
`endif

endmodule
